// ----- hw/rtl/tmd_pkg.sv -----
// Package for the tagged message deframer.
// Holds the result item type, the configuration bundle and the shared codes.
// No dependencies.
package tmd_pkg;

    // Magic header bytes that mark a framed payload.
    localparam logic [7:0] MAGIC_0 = 8'hFF;
    localparam logic [7:0] MAGIC_1 = 8'hA3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VALUE_TYPE   = 2'd0;
    localparam logic [1:0] CFG_UNKNOWN_TYPE = 2'd1;
    localparam logic [1:0] CFG_OPTION_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  RST_VALUE_TYPE   = 8'd0;
    localparam logic [7:0]  RST_UNKNOWN_TYPE = 8'd255;
    localparam logic [31:0] RST_OPTION_LIMIT = 32'd1024;

    // Section tags.
    localparam logic [2:0] SEC_HEADER  = 3'd0;
    localparam logic [2:0] SEC_OPTION  = 3'd1;
    localparam logic [2:0] SEC_DATA    = 3'd2;
    localparam logic [2:0] SEC_RAW     = 3'd3;
    localparam logic [2:0] SEC_IGNORED = 3'd4;

    // Status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_TRUNC    = 2'd1;
    localparam logic [1:0] STAT_OPT_OVER = 2'd2;

    // Result queue depth.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration registers as seen by the parser.
    typedef struct packed {
        logic [7:0]  value_type;
        logic [7:0]  unknown_type;
        logic [31:0] option_limit;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  section;
        logic [7:0]  msg_version;
        logic [7:0]  msg_type;
        logic [31:0] option_length;
        logic [31:0] data_length;
        logic        framed;
        logic [1:0]  status;
        logic        last_out;
    } t_result;

endpackage

// ----- hw/rtl/tmd_parse.sv -----
// Byte parser of the tagged message deframer: payload state and result building.
// Depends on tmd_pkg.
module tmd_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte_in,
    input  logic             i_last_in,
    input  tmd_pkg::t_cfg    i_cfg,
    output logic [1:0]       o_push_cnt,
    output tmd_pkg::t_result o_res0,
    output tmd_pkg::t_result o_res1
);
    import tmd_pkg::*;

    // Parser phases.
    localparam logic [3:0] PH_START  = 4'd0;
    localparam logic [3:0] PH_SECOND = 4'd1;
    localparam logic [3:0] PH_VER    = 4'd2;
    localparam logic [3:0] PH_TYPE   = 4'd3;
    localparam logic [3:0] PH_OLEN   = 4'd4;
    localparam logic [3:0] PH_OPT    = 4'd5;
    localparam logic [3:0] PH_DLEN   = 4'd6;
    localparam logic [3:0] PH_DATA   = 4'd7;
    localparam logic [3:0] PH_TRAIL  = 4'd8;
    localparam logic [3:0] PH_REST   = 4'd9;
    localparam logic [3:0] PH_RAW    = 4'd10;
    localparam logic [3:0] PH_OVER   = 4'd11;

    logic [3:0]  r_phase,   n_phase;
    logic [31:0] r_count,   n_count;
    logic [7:0]  r_held,    n_held;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_type,    n_type;
    logic [31:0] r_olen,    n_olen;
    logic [31:0] r_dlen,    n_dlen;
    logic        r_framed,  n_framed;
    logic [1:0]  r_status,  n_status;

    logic [2:0]  sec;
    logic        has_main;
    logic        has_two;
    logic        need_more;
    logic [1:0]  stat;
    t_result     first_res;
    t_result     main_res;

    // Next payload state and the results of one item.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_held    = r_held;
        n_version = r_version;
        n_type    = r_type;
        n_olen    = r_olen;
        n_dlen    = r_dlen;
        n_framed  = r_framed;
        n_status  = r_status;
        sec       = SEC_IGNORED;
        has_main  = 1'b1;
        has_two   = 1'b0;
        first_res = '0;

        unique case (r_phase)
            PH_START: begin
                if (i_last_in) begin
                    n_framed = 1'b0;
                    n_dlen   = 32'd1;
                    sec      = SEC_RAW;
                end else begin
                    n_held   = i_byte_in;
                    n_phase  = PH_SECOND;
                    has_main = 1'b0;
                end
            end
            PH_SECOND: begin
                has_two                 = 1'b1;
                first_res.byte_out      = r_held;
                first_res.msg_version   = r_version;
                first_res.option_length = r_olen;
                first_res.status        = STAT_OK;
                first_res.last_out      = 1'b0;
                if (r_held == MAGIC_0 && i_byte_in == MAGIC_1) begin
                    n_framed              = 1'b1;
                    first_res.section     = SEC_HEADER;
                    first_res.msg_type    = r_type;
                    first_res.data_length = r_dlen;
                    first_res.framed      = 1'b1;
                    sec                   = SEC_HEADER;
                    n_phase               = PH_VER;
                end else begin
                    n_framed              = 1'b0;
                    first_res.section     = SEC_RAW;
                    first_res.msg_type    = i_cfg.unknown_type;
                    first_res.data_length = 32'd1;
                    first_res.framed      = 1'b0;
                    n_dlen                = 32'd2;
                    sec                   = SEC_RAW;
                    n_phase               = PH_RAW;
                end
            end
            PH_VER: begin
                n_version = i_byte_in;
                sec       = SEC_HEADER;
                n_phase   = PH_TYPE;
            end
            PH_TYPE: begin
                n_type  = i_byte_in;
                sec     = SEC_HEADER;
                n_count = 32'd0;
                n_phase = PH_OLEN;
            end
            PH_OLEN: begin
                n_olen  = {r_olen[23:0], i_byte_in};
                sec     = SEC_HEADER;
                n_count = r_count + 32'd1;
                if (r_count == 32'd3) begin
                    if (n_olen > i_cfg.option_limit) begin
                        n_status = STAT_OPT_OVER;
                        n_phase  = PH_OVER;
                    end else if (n_olen == 32'd0) begin
                        n_count = 32'd0;
                        n_phase = (r_type == i_cfg.value_type) ? PH_DLEN : PH_REST;
                    end else begin
                        n_count = n_olen;
                        n_phase = PH_OPT;
                    end
                end
            end
            PH_OPT: begin
                sec     = SEC_OPTION;
                n_count = r_count - 32'd1;
                if (r_count == 32'd1) begin
                    n_count = 32'd0;
                    n_phase = (r_type == i_cfg.value_type) ? PH_DLEN : PH_REST;
                end
            end
            PH_DLEN: begin
                n_dlen  = {r_dlen[23:0], i_byte_in};
                sec     = SEC_HEADER;
                n_count = r_count + 32'd1;
                if (r_count == 32'd3) begin
                    n_count = n_dlen;
                    n_phase = (n_dlen == 32'd0) ? PH_TRAIL : PH_DATA;
                end
            end
            PH_DATA: begin
                sec     = SEC_DATA;
                n_count = r_count - 32'd1;
                if (r_count == 32'd1) begin
                    n_phase = PH_TRAIL;
                end
            end
            PH_REST: begin
                sec = SEC_DATA;
                if (r_dlen != 32'hFFFF_FFFF) begin
                    n_dlen = r_dlen + 32'd1;
                end
            end
            PH_RAW: begin
                sec = SEC_RAW;
                if (r_dlen != 32'hFFFF_FFFF) begin
                    n_dlen = r_dlen + 32'd1;
                end
            end
            default: begin
                sec = SEC_IGNORED;
            end
        endcase

        // A final byte that leaves a header, option or declared data section
        // unfinished reports a truncated payload, unless overflow was flagged.
        need_more = (n_phase == PH_VER)  || (n_phase == PH_TYPE) ||
                    (n_phase == PH_OLEN) || (n_phase == PH_OPT)  ||
                    (n_phase == PH_DLEN) || (n_phase == PH_DATA);
        stat = n_status;
        if (i_last_in && n_status == STAT_OK && need_more) begin
            stat = STAT_TRUNC;
        end

        main_res.byte_out      = i_byte_in;
        main_res.section       = sec;
        main_res.msg_version   = n_version;
        main_res.msg_type      = n_framed ? n_type : i_cfg.unknown_type;
        main_res.option_length = n_olen;
        main_res.data_length   = n_dlen;
        main_res.framed        = n_framed;
        main_res.status        = stat;
        main_res.last_out      = i_last_in;

        // The final byte returns all payload state to its start values.
        if (i_last_in) begin
            n_phase   = PH_START;
            n_count   = 32'd0;
            n_held    = 8'd0;
            n_version = 8'd0;
            n_type    = 8'd0;
            n_olen    = 32'd0;
            n_dlen    = 32'd0;
            n_framed  = 1'b0;
            n_status  = STAT_OK;
        end
    end

    // Results in queue order: the held first byte leads when there are two.
    always_comb begin
        if (has_two) begin
            o_res0 = first_res;
            o_res1 = main_res;
        end else begin
            o_res0 = main_res;
            o_res1 = main_res;
        end
        if (!i_accept) begin
            o_push_cnt = 2'd0;
        end else if (has_two) begin
            o_push_cnt = 2'd2;
        end else begin
            o_push_cnt = {1'b0, has_main};
        end
    end

    // Payload state registers, advanced on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_count   <= 32'd0;
            r_held    <= 8'd0;
            r_version <= 8'd0;
            r_type    <= 8'd0;
            r_olen    <= 32'd0;
            r_dlen    <= 32'd0;
            r_framed  <= 1'b0;
            r_status  <= STAT_OK;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_held    <= n_held;
            r_version <= n_version;
            r_type    <= n_type;
            r_olen    <= n_olen;
            r_dlen    <= n_dlen;
            r_framed  <= n_framed;
            r_status  <= n_status;
        end
    end

endmodule

// ----- hw/rtl/tmd_outq.sv -----
// Result queue of the tagged message deframer: a short shifting queue that
// takes up to two items per cycle and hands out one when popped. Depends on tmd_pkg.
module tmd_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  tmd_pkg::t_result i_res0,
    input  tmd_pkg::t_result i_res1,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output tmd_pkg::t_result o_head
);
    import tmd_pkg::*;

    localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);

    t_result           r_slot [QUEUE_DEPTH];
    t_result           n_slot [QUEUE_DEPTH];
    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  n_occ;
    logic [OCC_W-1:0]  base;
    logic              do_pop;

    assign do_pop  = i_pop && (r_occ != '0);
    assign base    = r_occ - OCC_W'(do_pop);
    assign n_occ   = base + OCC_W'(i_push_cnt);
    assign o_valid = (r_occ != '0);
    assign o_head  = r_slot[0];
    // Hold off input while fewer than two free places could remain.
    assign o_full  = (r_occ > OCC_W'(QUEUE_DEPTH - 2));

    // Each place shifts toward the head on a pop and loads new items at the tail.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (do_pop && i < QUEUE_DEPTH - 1) begin
                n_slot[i] = r_slot[i + 1];
            end else begin
                n_slot[i] = r_slot[i];
            end
            if (i_push_cnt != 2'd0 && base == OCC_W'(i)) begin
                n_slot[i] = i_res0;
            end
            if (i_push_cnt == 2'd2 && base + OCC_W'(1) == OCC_W'(i)) begin
                n_slot[i] = i_res1;
            end
        end
    end

    // Queue places carry payload only.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    // Fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

endmodule

// ----- hw/rtl/tagged_message_deframer.sv -----
// Tagged message deframer: results of an accepted item are registered in the
// result queue; the first byte of a payload waits for the second byte.
// Throughput is one item per cycle while the output does not stall, set by
// the single-pass parser and a four-place result queue; a payload of N bytes
// yields N results. Synchronous active-low reset clears the payload state,
// the queue and the configuration registers to their defaults.
module tagged_message_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_in,
    // Output channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_byte_out,
    output logic [2:0]  o_section,
    output logic [7:0]  o_msg_version,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_option_length,
    output logic [31:0] o_data_length,
    output logic        o_framed,
    output logic [1:0]  o_status,
    output logic        o_last_out
);
    import tmd_pkg::*;

    t_cfg       r_cfg;
    logic       accept;
    logic       q_full;
    logic [1:0] push_cnt;
    t_result    res0;
    t_result    res1;
    t_result    head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.value_type   <= RST_VALUE_TYPE;
            r_cfg.unknown_type <= RST_UNKNOWN_TYPE;
            r_cfg.option_limit <= RST_OPTION_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VALUE_TYPE:   r_cfg.value_type   <= i_cfg_wdata[7:0];
                CFG_UNKNOWN_TYPE: r_cfg.unknown_type <= i_cfg_wdata[7:0];
                CFG_OPTION_LIMIT: r_cfg.option_limit <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Input handshake.
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    tmd_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte_in  (i_byte_in),
        .i_last_in  (i_last_in),
        .i_cfg      (r_cfg),
        .o_push_cnt (push_cnt),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    tmd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (!i_stall),
        .o_valid    (o_valid),
        .o_full     (q_full),
        .o_head     (head)
    );

    // Result item fields.
    assign o_byte_out      = head.byte_out;
    assign o_section       = head.section;
    assign o_msg_version   = head.msg_version;
    assign o_msg_type      = head.msg_type;
    assign o_option_length = head.option_length;
    assign o_data_length   = head.data_length;
    assign o_framed        = head.framed;
    assign o_status        = head.status;
    assign o_last_out      = head.last_out;

endmodule

// ----- verif/tagged_message_deframer_chk.sv -----
`timescale 1ns / 1ps
// Checker for the tagged message deframer: follows the configuration port and both
// item channels, predicts every result item and compares it field by field.
// Depends on tmd_pkg.
module tagged_message_deframer_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_byte_out,
    input  logic [2:0]  i_section,
    input  logic [7:0]  i_msg_version,
    input  logic [7:0]  i_msg_type,
    input  logic [31:0] i_option_length,
    input  logic [31:0] i_data_length,
    input  logic        i_framed,
    input  logic [1:0]  i_status,
    input  logic        i_last_out,
    output int          o_errors,
    output int          o_pending
);
    import tmd_pkg::*;

    // Parser position within the payload.
    typedef enum logic [3:0] {
        PH_START, PH_SECOND, PH_VER, PH_TYPE, PH_OLEN, PH_OPT,
        PH_DLEN, PH_DATA, PH_TRAIL, PH_REST, PH_RAW, PH_OVER
    } t_phase;

    // Configuration as last written.
    logic [7:0]  cfg_value_type;
    logic [7:0]  cfg_unknown_type;
    logic [31:0] cfg_option_limit;

    // Payload state of the predictor.
    t_phase      phase;
    logic [31:0] field_count;
    logic [7:0]  held_byte;
    logic [7:0]  version_q;
    logic [7:0]  type_q;
    logic [31:0] opt_len_q;
    logic [31:0] data_len_q;
    logic        framed_q;
    logic [1:0]  status_q;

    // Result items predicted but not yet seen, oldest first.
    t_result     pending_results[$];

    task automatic clear_payload();
        phase       = PH_START;
        field_count = '0;
        held_byte   = '0;
        version_q   = '0;
        type_q      = '0;
        opt_len_q   = '0;
        data_len_q  = '0;
        framed_q    = 1'b0;
        status_q    = STAT_OK;
    endtask

    // Queue one result item tagged with the header decoded so far.
    task automatic push_result(input logic [7:0] b, input logic [2:0] sec,
                               input logic [1:0] stat, input logic lst);
        t_result r;
        r.byte_out      = b;
        r.section       = sec;
        r.msg_version   = version_q;
        r.msg_type      = framed_q ? type_q : cfg_unknown_type;
        r.option_length = opt_len_q;
        r.data_length   = data_len_q;
        r.framed        = framed_q;
        r.status        = stat;
        r.last_out      = lst;
        pending_results.push_back(r);
    endtask

    // Only the value type carries an explicit data length.
    task automatic options_done();
        field_count = '0;
        phase = (type_q == cfg_value_type) ? PH_DLEN : PH_REST;
    endtask

    // Advance the parser by one accepted byte and queue what it yields.
    task automatic deframe_byte(input logic [7:0] b, input logic lst);
        logic [2:0] sec;
        logic [1:0] stat;
        sec = SEC_IGNORED;
        if (phase == PH_START) begin
            // A lone byte comes out as raw data; otherwise it waits for the second.
            if (lst) begin
                framed_q   = 1'b0;
                data_len_q = 32'd1;
                push_result(b, SEC_RAW, STAT_OK, 1'b1);
                clear_payload();
            end else begin
                held_byte = b;
                phase     = PH_SECOND;
            end
        end else begin
            case (phase)
                PH_SECOND: begin
                    if (held_byte == MAGIC_0 && b == MAGIC_1) begin
                        framed_q = 1'b1;
                        push_result(held_byte, SEC_HEADER, STAT_OK, 1'b0);
                        sec   = SEC_HEADER;
                        phase = PH_VER;
                    end else begin
                        framed_q   = 1'b0;
                        data_len_q = 32'd1;
                        push_result(held_byte, SEC_RAW, STAT_OK, 1'b0);
                        data_len_q = 32'd2;
                        sec   = SEC_RAW;
                        phase = PH_RAW;
                    end
                end
                PH_VER: begin
                    version_q = b;
                    sec   = SEC_HEADER;
                    phase = PH_TYPE;
                end
                PH_TYPE: begin
                    type_q      = b;
                    sec         = SEC_HEADER;
                    field_count = '0;
                    phase       = PH_OLEN;
                end
                PH_OLEN: begin
                    opt_len_q   = {opt_len_q[23:0], b};
                    sec         = SEC_HEADER;
                    field_count = field_count + 32'd1;
                    if (field_count >= 32'd4) begin
                        if (opt_len_q > cfg_option_limit) begin
                            status_q = STAT_OPT_OVER;
                            phase    = PH_OVER;
                        end else if (opt_len_q == 32'd0) begin
                            options_done();
                        end else begin
                            field_count = opt_len_q;
                            phase       = PH_OPT;
                        end
                    end
                end
                PH_OPT: begin
                    sec         = SEC_OPTION;
                    field_count = field_count - 32'd1;
                    if (field_count == 32'd0) begin
                        options_done();
                    end
                end
                PH_DLEN: begin
                    data_len_q  = {data_len_q[23:0], b};
                    sec         = SEC_HEADER;
                    field_count = field_count + 32'd1;
                    if (field_count >= 32'd4) begin
                        field_count = data_len_q;
                        phase = (data_len_q == 32'd0) ? PH_TRAIL : PH_DATA;
                    end
                end
                PH_DATA: begin
                    sec         = SEC_DATA;
                    field_count = field_count - 32'd1;
                    if (field_count == 32'd0) begin
                        phase = PH_TRAIL;
                    end
                end
                PH_REST, PH_RAW: begin
                    // Running byte count, saturating at the top of its range.
                    sec = (phase == PH_REST) ? SEC_DATA : SEC_RAW;
                    if (data_len_q != 32'hFFFF_FFFF) begin
                        data_len_q = data_len_q + 32'd1;
                    end
                end
                default: begin
                    sec = SEC_IGNORED;
                end
            endcase

            // Ending inside the header, the options or declared data is an early end.
            stat = status_q;
            if (lst && stat == STAT_OK &&
                (phase == PH_VER || phase == PH_TYPE || phase == PH_OLEN ||
                 phase == PH_OPT || phase == PH_DLEN || phase == PH_DATA)) begin
                stat = STAT_TRUNC;
            end
            push_result(b, sec, stat, lst);
            if (lst) begin
                clear_payload();
            end
        end
    endtask

    // One line per mismatch, and the count goes up.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        o_errors = o_errors + 1;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Compare an accepted result item with the oldest prediction.
    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result item", {24'd0, i_byte_out}, 32'd0);
        end else begin
            want = pending_results.pop_front();
            compare_field("byte_out", {24'd0, i_byte_out}, {24'd0, want.byte_out});
            compare_field("section", {29'd0, i_section}, {29'd0, want.section});
            compare_field("msg_version", {24'd0, i_msg_version}, {24'd0, want.msg_version});
            compare_field("msg_type", {24'd0, i_msg_type}, {24'd0, want.msg_type});
            compare_field("option_length", i_option_length, want.option_length);
            compare_field("data_length", i_data_length, want.data_length);
            compare_field("framed", {31'd0, i_framed}, {31'd0, want.framed});
            compare_field("status", {30'd0, i_status}, {30'd0, want.status});
            compare_field("last_out", {31'd0, i_last_out}, {31'd0, want.last_out});
        end
    endtask

    // Follow configuration writes, predict on input items, check output items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_value_type   = RST_VALUE_TYPE;
            cfg_unknown_type = RST_UNKNOWN_TYPE;
            cfg_option_limit = RST_OPTION_LIMIT;
            clear_payload();
            pending_results.delete();
            o_errors = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VALUE_TYPE:   cfg_value_type   = i_cfg_wdata[7:0];
                    CFG_UNKNOWN_TYPE: cfg_unknown_type = i_cfg_wdata[7:0];
                    CFG_OPTION_LIMIT: cfg_option_limit = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                deframe_byte(i_byte_in, i_last_in);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ----- verif/tagged_message_deframer_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the tagged message deframer: clock, reset, configuration
// phases and payload stimulus; the checker beside the block does the comparing.
// Depends on tmd_pkg, tagged_message_deframer and tagged_message_deframer_chk.
module tagged_message_deframer_tb;
    import tmd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 160;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_VALUE_TYPE;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [2:0]  out_section;
    logic [7:0]  out_version;
    logic [7:0]  out_type;
    logic [31:0] out_opt_len;
    logic [31:0] out_data_len;
    logic        out_framed;
    logic [1:0]  out_status;
    logic        out_last;

    int          errors;
    int          pending;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    logic        quiet = 1'b0;
    logic [7:0]  cur_value_type = RST_VALUE_TYPE;
    logic [7:0]  payload_bytes[$];

    tagged_message_deframer DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_valid         (in_valid),
        .o_stall         (in_stall),
        .i_byte_in       (in_byte),
        .i_last_in       (in_last),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_byte_out      (out_byte),
        .o_section       (out_section),
        .o_msg_version   (out_version),
        .o_msg_type      (out_type),
        .o_option_length (out_opt_len),
        .o_data_length   (out_data_len),
        .o_framed        (out_framed),
        .o_status        (out_status),
        .o_last_out      (out_last)
    );

    tagged_message_deframer_chk u_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_byte_in       (in_byte),
        .i_last_in       (in_last),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_byte_out      (out_byte),
        .i_section       (out_section),
        .i_msg_version   (out_version),
        .i_msg_type      (out_type),
        .i_option_length (out_opt_len),
        .i_data_length   (out_data_len),
        .i_framed        (out_framed),
        .i_status        (out_status),
        .i_last_out      (out_last),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // 20 ns clock.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The result side stalls about a third of the time, except in the quiet stretch.
    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 34);
    end

    // Give up if the run hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tagged_message_deframer_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    task automatic push_be32(input logic [31:0] v);
        payload_bytes.push_back(v[31:24]);
        payload_bytes.push_back(v[23:16]);
        payload_bytes.push_back(v[15:8]);
        payload_bytes.push_back(v[7:0]);
    endtask

    // Offer one item after idle cycles drawn one at a time, about a third of all
    // cycles, and hold it until accepted.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        while (!quiet && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= lst;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_payload();
        for (int k = 0; k < payload_bytes.size(); k++) begin
            send_byte(payload_bytes[k], k == payload_bytes.size() - 1);
        end
        items_sent = items_sent + payload_bytes.size();
    endtask

    // All three registers in back-to-back writes, write enable held high throughout.
    task automatic set_config(input logic [7:0] vt, input logic [7:0] ut,
                              input logic [31:0] lim);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_VALUE_TYPE;
        cfg_wdata <= {24'd0, vt};
        @(posedge clk);
        cfg_idx   <= CFG_UNKNOWN_TYPE;
        cfg_wdata <= {24'd0, ut};
        @(posedge clk);
        cfg_idx   <= CFG_OPTION_LIMIT;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_value_type = vt;
    endtask

    // Mostly well-formed framed payloads with random content, plus raw noise,
    // truncated payloads and payloads declaring huge lengths.
    task automatic build_random_payload();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  msg_ty;
        logic [31:0] olen;
        logic [31:0] dlen;
        pick = $urandom_range(99);
        payload_bytes.delete();
        if (pick < 15) begin
            // Unframed; a leading FF makes the second byte decide.
            n = $urandom_range(1, 8);
            payload_bytes.push_back(($urandom_range(1) == 0) ? MAGIC_0 : rand_byte());
            repeat (n - 1) payload_bytes.push_back(rand_byte());
        end else begin
            payload_bytes.push_back(MAGIC_0);
            payload_bytes.push_back(MAGIC_1);
            payload_bytes.push_back(rand_byte());
            msg_ty = ($urandom_range(1) == 0) ? cur_value_type : rand_byte();
            payload_bytes.push_back(msg_ty);
            if (pick >= 90) begin
                // Huge declared lengths; the payload ends long before them.
                if ($urandom_range(1) == 0 || msg_ty != cur_value_type) begin
                    olen = $urandom;
                    push_be32(olen);
                end else begin
                    push_be32(32'd0);
                    dlen = $urandom;
                    push_be32(dlen);
                end
                repeat ($urandom_range(0, 4)) payload_bytes.push_back(rand_byte());
            end else begin
                olen = $urandom_range(0, 5);
                push_be32(olen);
                repeat (olen) payload_bytes.push_back(rand_byte());
                if (msg_ty == cur_value_type) begin
                    dlen = $urandom_range(0, 5);
                    push_be32(dlen);
                    repeat (dlen) payload_bytes.push_back(rand_byte());
                    repeat ($urandom_range(0, 2)) payload_bytes.push_back(rand_byte());
                end else begin
                    repeat ($urandom_range(0, 6)) payload_bytes.push_back(rand_byte());
                end
                // Cut some payloads short at a random point.
                if (pick >= 75) begin
                    n = $urandom_range(1, payload_bytes.size() - 1);
                    while (payload_bytes.size() > n) void'(payload_bytes.pop_back());
                end
            end
        end
    endtask

    initial begin
        int unsigned target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed payloads at the reset configuration (value type 00, limit 1024).
        payload_bytes = '{8'h00};
        send_payload();
        payload_bytes = '{8'hFF, 8'hFE};
        send_payload();
        payload_bytes = '{8'hFF, 8'hA3};
        send_payload();
        // Value type whose option length 0x401 is just over the limit.
        payload_bytes = '{8'hFF, 8'hA3, 8'h07, 8'h00, 8'h00, 8'h00, 8'h04, 8'h01, 8'hE5};
        send_payload();
        // Other type: one option byte, then everything left is data.
        payload_bytes = '{8'hFF, 8'hA3, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01,
                          8'h80, 8'h7F};
        send_payload();

        // Random payloads under a series of configurations, extremes included.
        for (int p = 0; p < 5; p++) begin
            case (p)
                1: set_config(8'hFF, 8'h00, 32'h0000_0000);
                2: set_config(8'h00, 8'hFF, 32'hFFFF_FFFF);
                3: set_config(rand_byte(), rand_byte(), 32'd3);
                4: set_config(8'h5A, 8'h80, RST_OPTION_LIMIT);
                default: ;
            endcase
            quiet  = (p == 2);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                build_random_payload();
                send_payload();
            end
            // Let every result drain before touching the configuration again.
            in_valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
            repeat (8) @(posedge clk);
        end

        if (errors == 0) begin
            $display("tagged_message_deframer_tb OK");
        end else begin
            $display("tagged_message_deframer_tb NOT OK");
        end
        $finish;
    end

endmodule
